// ----- hw/rtl/rdq_pkg.sv -----
`default_nettype none

package rdq_pkg;

    localparam int SLOTS = 64;
    localparam int PTR_W = $clog2(SLOTS);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SLOTS - 1);

    localparam logic [1:0] CMD_PUSH_BACK  = 2'd0;
    localparam logic [1:0] CMD_PUSH_FRONT = 2'd1;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] data_in;
    } t_in_word;

    typedef struct packed {
        logic [31:0] data_out;
        logic [1:0]  status;
        logic [5:0]  occupancy;
    } t_out_word;

    function automatic logic [PTR_W-1:0] slot_next(input logic [PTR_W-1:0] s);
        return (s == PTR_LAST) ? '0 : s + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] slot_prev(input logic [PTR_W-1:0] s);
        return (s == '0) ? PTR_LAST : s - PTR_W'(1);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rdq_ram.sv -----
`default_nettype none

module rdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ring_deque_front_back_push.sv -----
`default_nettype none

// Circular deque of rdq_pkg::SLOTS - 1 words held in a single-port-write RAM ring.
// Each accepted word is one command (push at back, push at front or pop from the
// front) and yields exactly one result word in the next cycle, carrying the popped
// data, a status code and the occupancy after the command. A command is taken in
// every cycle while the result register is empty or being drained, so the block
// sustains one command per cycle; the rate is set by the single RAM write and read
// port, which each command uses at most once. A push onto a full deque is rejected
// and a pop on an empty one returns zero with the empty status.

module ring_deque_front_back_push (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire rdq_pkg::t_in_word i_in_word,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output rdq_pkg::t_out_word     o_out_word
);

    logic [rdq_pkg::PTR_W-1:0] r_head_gap;
    logic [rdq_pkg::PTR_W-1:0] r_tail_slot;
    logic [rdq_pkg::PTR_W-1:0] n_head_gap;
    logic [rdq_pkg::PTR_W-1:0] n_tail_slot;

    logic        r_out_valid;
    logic        r_pop_ok;
    logic [1:0]  r_status;
    logic [5:0]  r_occupancy;
    logic        n_pop_ok;
    logic [1:0]  n_status;
    logic [5:0]  n_occupancy;

    logic                      accept;
    logic                      ram_we;
    logic [rdq_pkg::PTR_W-1:0] ram_waddr;
    logic                      ram_re;
    logic [31:0]               ram_rdata;
    logic [rdq_pkg::PTR_W-1:0] back_slot;
    logic [rdq_pkg::PTR_W-1:0] front_slot;
    logic [rdq_pkg::PTR_W:0]   count;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign back_slot  = rdq_pkg::slot_next(r_tail_slot);
    assign front_slot = rdq_pkg::slot_prev(r_head_gap);

    always_comb begin
        n_head_gap  = r_head_gap;
        n_tail_slot = r_tail_slot;
        n_status    = rdq_pkg::ST_OK;
        n_pop_ok    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = back_slot;
        unique case (i_in_word.cmd)
            rdq_pkg::CMD_PUSH_BACK: begin
                if (back_slot == r_head_gap) begin
                    n_status = rdq_pkg::ST_FULL;
                end else begin
                    ram_we      = 1'b1;
                    n_tail_slot = back_slot;
                end
            end
            rdq_pkg::CMD_PUSH_FRONT: begin
                ram_waddr = r_head_gap;
                if (front_slot == r_tail_slot) begin
                    n_status = rdq_pkg::ST_FULL;
                end else begin
                    ram_we     = 1'b1;
                    n_head_gap = front_slot;
                end
            end
            rdq_pkg::CMD_POP_FRONT: begin
                if (r_head_gap == r_tail_slot) begin
                    n_status = rdq_pkg::ST_EMPTY;
                end else begin
                    n_pop_ok   = 1'b1;
                    n_head_gap = rdq_pkg::slot_next(r_head_gap);
                end
            end
            default: begin
            end
        endcase
        if (n_tail_slot >= n_head_gap) begin
            count = {1'b0, n_tail_slot} - {1'b0, n_head_gap};
        end else begin
            count = {1'b0, n_tail_slot} + (rdq_pkg::PTR_W + 1)'(rdq_pkg::SLOTS)
                    - {1'b0, n_head_gap};
        end
        n_occupancy = 6'(count);
    end

    assign ram_re = accept && n_pop_ok;

    rdq_ram #(
        .WIDTH(32),
        .DEPTH(rdq_pkg::SLOTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (accept && ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_in_word.data_in),
        .i_re   (ram_re),
        .i_raddr(n_head_gap),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_gap  <= rdq_pkg::PTR_LAST;
            r_tail_slot <= rdq_pkg::PTR_LAST;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_head_gap  <= n_head_gap;
                r_tail_slot <= n_tail_slot;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pop_ok    <= n_pop_ok;
            r_status    <= n_status;
            r_occupancy <= n_occupancy;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_word.data_out  = r_pop_ok ? ram_rdata : 32'd0;
    assign o_out_word.status    = r_status;
    assign o_out_word.occupancy = r_occupancy;

endmodule

`default_nettype wire
